@@ hdl/lrbd_pkg.sv @@
`default_nettype none

package lrbd_pkg;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int LABEL_BITS_DEF  = 32;

    localparam int PIX_LABEL_BITS  = 32;
    localparam int COL_BITS        = 12;
    localparam int ROW_BITS        = 16;

    localparam int CFG_INDEX_BITS  = 2;
    localparam int CFG_DATA_BITS   = 32;
    localparam int WIDTH_REG_BITS  = 13;
    localparam int HEIGHT_REG_BITS = 16;

    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 13'd4096;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd1;

    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_NODATA_ENABLE = 2'd2,
        CFG_NODATA_VALUE  = 2'd3
    } t_cfg_index;

    // One queue entry holds every result caused by one pixel request:
    // the upper-row result (a) and the own-row result on the last row (b).
    typedef struct packed {
        logic                has_a;
        logic                has_b;
        logic                flag_a;
        logic                flag_b;
        logic                done;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
    } t_entry;

endpackage

`default_nettype wire

@@ hdl/lrbd_pixel_if.sv @@
`default_nettype none

interface lrbd_pixel_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [lrbd_pkg::PIX_LABEL_BITS-1:0] pixel_label;
    logic                                      in_mask;

    modport source (output valid, output pixel_label, output in_mask, input ready);
    modport sink   (input valid, input pixel_label, input in_mask, output ready);
endinterface

`default_nettype wire

@@ hdl/lrbd_result_if.sv @@
`default_nettype none

interface lrbd_result_if;
    logic                          valid;
    logic                          ready;
    logic                          boundary_flag;
    logic [lrbd_pkg::COL_BITS-1:0] result_col;
    logic [lrbd_pkg::ROW_BITS-1:0] result_row;
    logic                          last_of_item;
    logic                          frame_done;

    modport source (output valid, output boundary_flag, output result_col,
                    output result_row, output last_of_item, output frame_done,
                    input ready);
    modport sink   (input valid, input boundary_flag, input result_col,
                    input result_row, input last_of_item, input frame_done,
                    output ready);
endinterface

`default_nettype wire

@@ hdl/label_raster_boundary_detect_top.sv @@
// Four-neighbour label boundary detector. Pixels arrive in raster order, one
// request per pixel (label and mask); a pixel is valid when masked and its
// label is not the enabled nodata value. When pixel (x, y) arrives the flag
// for (x, y-1) is produced; on the last row the flag for (x, y) follows in the
// same queue entry, and row 0 of a multi-row frame produces nothing. A pixel
// request is taken every cycle while the queue has room; the result port moves
// one result per cycle while the sink is ready, so two results per last-row
// pixel hold back the input. An accepted request reaches the queue in the next
// cycle: the row stores (two single-port-read block memories, one read and one
// write per cycle) are read at the request edge and written back from stage 2,
// with forwarding for back-to-back hits on the same column. The row stores have
// no reset and need no clearing pass; an entry read before it is written within
// the frame never reaches a result. The user writes configuration through the
// plain write port while no pixel is in flight; the block does not enforce it.
`default_nettype none

module label_raster_boundary_detect_top #(
    parameter int MAX_WIDTH  = lrbd_pkg::MAX_WIDTH_DEF,
    parameter int LABEL_BITS = lrbd_pkg::LABEL_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    lrbd_pixel_if.sink                               i_pix,
    lrbd_result_if.source                            o_res,
    input  wire logic                                i_cfg_we,
    input  wire logic [lrbd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [lrbd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);   // column index bits
    localparam int WW = CW + 1;              // holds the width itself
    localparam int RW = lrbd_pkg::ROW_BITS;

    typedef struct packed {
        logic                  mask;
        logic [LABEL_BITS-1:0] lab;
    } t_pix;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [lrbd_pkg::WIDTH_REG_BITS-1:0]  r_width;
    logic [lrbd_pkg::HEIGHT_REG_BITS-1:0] r_height;
    logic                                 r_nd_en;
    logic signed [lrbd_pkg::CFG_DATA_BITS-1:0] r_nd_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lrbd_pkg::WIDTH_RESET;
            r_height <= lrbd_pkg::HEIGHT_RESET;
            r_nd_en  <= 1'b0;
            r_nd_val <= '0;
        end else if (i_cfg_we) begin
            case (lrbd_pkg::t_cfg_index'(i_cfg_index))
                lrbd_pkg::CFG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[lrbd_pkg::WIDTH_REG_BITS-1:0];
                end
                lrbd_pkg::CFG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[lrbd_pkg::HEIGHT_REG_BITS-1:0];
                end
                lrbd_pkg::CFG_NODATA_ENABLE: begin
                    r_nd_en <= i_cfg_data[0];
                end
                lrbd_pkg::CFG_NODATA_VALUE: begin
                    r_nd_val <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp width into 1..MAX_WIDTH and height to at least 1
    logic [WW-1:0] width_eff;
    logic [RW-1:0] height_eff;
    logic [LABEL_BITS-1:0] nd_lab;

    always_comb begin
        if (r_width == '0) begin
            width_eff = WW'(1);
        end else if (32'(r_width) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_width);
        end
        height_eff = (r_height == '0) ? RW'(1) : r_height;
        nd_lab     = r_nd_val[LABEL_BITS-1:0];
    end

    // ---------------------------------------------------------------
    // Raster position and request acceptance
    // ---------------------------------------------------------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_s1_valid;

    logic [lrbd_pkg::QUEUE_PTR_BITS:0] q_level;
    logic          accept;
    logic          last_col;
    logic          last_row;
    logic [CW-1:0] la_addr;
    t_pix          in_pix;

    // take a request while the queue keeps room for the one in flight too
    assign i_pix.ready = (32'(q_level) + 32'(r_s1_valid)) < lrbd_pkg::QUEUE_DEPTH;
    assign accept      = i_pix.valid && i_pix.ready;

    always_comb begin
        in_pix.mask = i_pix.in_mask;
        in_pix.lab  = i_pix.pixel_label[LABEL_BITS-1:0];
        last_col    = (WW'(r_col) + WW'(1)) >= width_eff;
        last_row    = ({1'b0, r_row} + (RW+1)'(1)) >= {1'b0, height_eff};
        // look ahead to the next centre: right neighbour, or column 0 at row end
        la_addr     = last_col ? '0 : r_col + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1 capture: pixel, position, forwarding decisions
    // ---------------------------------------------------------------
    t_pix          r_s1_cur;
    logic [CW-1:0] r_s1_x;
    logic [RW-1:0] r_s1_y;
    logic          r_s1_last_col;
    logic          r_s1_last_row;
    logic          r_s1_self;
    logic          r_fwd_prev_hit;
    logic          r_fwd_older_hit;
    t_pix          r_fwd_prev;
    t_pix          r_fwd_older;
    t_pix          r_c;       // centre: upper-row pixel at this column
    t_pix          r_left;    // centre of the previous column

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cur        <= in_pix;
            r_s1_x          <= r_col;
            r_s1_y          <= r_row;
            r_s1_last_col   <= last_col;
            r_s1_last_row   <= last_row;
            r_s1_self       <= (la_addr == r_col);
            // the request in stage 2 writes its column at this same edge
            r_fwd_prev_hit  <= r_s1_valid && (r_s1_x == la_addr);
            r_fwd_older_hit <= r_s1_valid && (r_s1_x == r_col);
            r_fwd_prev      <= r_s1_cur;
            r_fwd_older     <= r_c;
        end
    end

    // ---------------------------------------------------------------
    // Row stores: read at acceptance, written back in stage 2
    // ---------------------------------------------------------------
    t_pix prev_mem  [MAX_WIDTH];
    t_pix older_mem [MAX_WIDTH];
    t_pix r_prev_rd;
    t_pix r_older_rd;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prev_rd <= prev_mem[la_addr];
        end
        if (r_s1_valid) begin
            prev_mem[r_s1_x] <= r_s1_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_older_rd <= older_mem[r_col];
        end
        if (r_s1_valid) begin
            older_mem[r_s1_x] <= r_c;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: neighbourhood test
    // ---------------------------------------------------------------
    t_pix right_nb;
    t_pix up_nb;
    logic c_valid;
    logic cur_valid;
    logic inner;
    logic push;
    logic [31:0] x_ext;
    lrbd_pkg::t_entry entry;

    always_comb begin
        right_nb  = r_fwd_prev_hit  ? r_fwd_prev  : r_prev_rd;
        up_nb     = r_fwd_older_hit ? r_fwd_older : r_older_rd;
        c_valid   = r_c.mask && !(r_nd_en && (r_c.lab == nd_lab));
        cur_valid = r_s1_cur.mask && !(r_nd_en && (r_s1_cur.lab == nd_lab));
        // with a valid centre, a neighbour of equal label and set mask is valid
        inner = (r_s1_x != '0) && r_left.mask && (r_left.lab == r_c.lab)
             && !r_s1_last_col && right_nb.mask && (right_nb.lab == r_c.lab)
             && (r_s1_y != RW'(1)) && up_nb.mask && (up_nb.lab == r_c.lab)
             && r_s1_cur.mask && (r_s1_cur.lab == r_c.lab);

        x_ext        = 32'(r_s1_x);
        entry.has_a  = (r_s1_y != '0);
        entry.has_b  = r_s1_last_row;
        entry.flag_a = c_valid && !inner;
        entry.flag_b = cur_valid;
        entry.done   = r_s1_last_col;
        entry.col    = x_ext[lrbd_pkg::COL_BITS-1:0];
        entry.row    = r_s1_y;
        push         = r_s1_valid && (entry.has_a || entry.has_b);
    end

    // advance the window; a one-pixel row is its own next centre
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_c    <= r_s1_self ? r_s1_cur : right_nb;
            r_left <= r_c;
        end
    end

    lrbd_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_level (q_level),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // stage 2 never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (32'(q_level) < lrbd_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // the frame's final result closes its request
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_done) |-> o_res.last_of_item)
        else $error("frame_done without last_of_item");

    // an upper-row result is followed by the own-row result of its column
    a_pair_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.ready && !o_res.last_of_item)
        |=> (o_res.valid && (o_res.result_col == $past(o_res.result_col))))
        else $error("split result pair lost its column");
`endif

endmodule

`default_nettype wire

@@ hdl/lrbd_result_queue.sv @@
`default_nettype none

module lrbd_result_queue (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    input  wire lrbd_pkg::t_entry                    i_entry,
    output logic [lrbd_pkg::QUEUE_PTR_BITS:0]        o_level,
    lrbd_result_if.source                            o_res
);

    localparam int PW = lrbd_pkg::QUEUE_PTR_BITS;

    lrbd_pkg::t_entry r_mem [lrbd_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [PW:0]      r_level;
    logic             r_sub;

    lrbd_pkg::t_entry head;
    logic             sel_b;
    logic             take;
    logic             pop;

    always_comb begin
        head  = r_mem[r_rd];
        // show the own-row result once the upper-row one is gone or absent
        sel_b = r_sub || !head.has_a;
        take  = o_res.valid && o_res.ready;
        pop   = take && (sel_b || !head.has_b);
    end

    assign o_res.valid         = (r_level != '0);
    assign o_res.boundary_flag = sel_b ? head.flag_b : head.flag_a;
    assign o_res.result_col    = head.col;
    assign o_res.result_row    = sel_b ? head.row : head.row - lrbd_pkg::ROW_BITS'(1);
    assign o_res.last_of_item  = sel_b || !head.has_b;
    assign o_res.frame_done    = sel_b && head.done;
    assign o_level             = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
            r_sub   <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + PW'(1);
            end
            if (i_push && !pop) begin
                r_level <= r_level + (PW+1)'(1);
            end else if (pop && !i_push) begin
                r_level <= r_level - (PW+1)'(1);
            end
            if (take) begin
                r_sub <= !pop;
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/lrbd_checker.sv @@
`timescale 1ns / 1ps

module lrbd_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    lrbd_pixel_if                                    i_pix,
    lrbd_result_if                                   i_res,
    input  wire logic                                i_cfg_we,
    input  wire logic [lrbd_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [lrbd_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                       o_fail_count,
    output int                                       o_pending
);

    localparam int ROW_SLOTS = lrbd_pkg::MAX_WIDTH_DEF;

    typedef struct packed {
        logic                          flag;
        logic [lrbd_pkg::COL_BITS-1:0] col;
        logic [lrbd_pkg::ROW_BITS-1:0] row;
        logic                          last_item;
        logic                          done;
    } t_boundary_result;

    // {mask, label} of the row above and of the row above that
    logic [32:0] upper_row [ROW_SLOTS];
    logic [32:0] older_row [ROW_SLOTS];

    logic [lrbd_pkg::WIDTH_REG_BITS-1:0]  width_reg;
    logic [lrbd_pkg::HEIGHT_REG_BITS-1:0] height_reg;
    logic                                 nodata_en;
    logic [lrbd_pkg::PIX_LABEL_BITS-1:0]  nodata_val;
    logic [lrbd_pkg::COL_BITS-1:0]        col_pos;
    logic [lrbd_pkg::ROW_BITS-1:0]        row_pos;

    t_boundary_result flags_due [$];
    int               fail_cnt = 0;
    int               pending_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    function automatic bit labelled(input logic [32:0] e);
        return (e[32] === 1'b1) && !(nodata_en && (e[31:0] === nodata_val));
    endfunction

    function automatic bit same_region(input logic [32:0] nb, input logic [32:0] ctr);
        return labelled(nb) && (nb[31:0] === ctr[31:0]);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_cnt++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Work out the flags that one pixel request releases and advance the raster position.
    task automatic predict_flags(input logic [31:0] label, input logic mask);
        int unsigned      w, h, x, y;
        bit               last_row, last_col, interior;
        logic [32:0]      cur, ctr;
        t_boundary_result r [2];
        int               n;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > ROW_SLOTS) w = ROW_SLOTS;
        h = height_reg;
        if (h < 1) h = 1;
        x = col_pos;
        y = row_pos;
        cur = {mask, label};
        last_row = (y + 1 >= h);
        last_col = (x + 1 >= w);
        n = 0;
        if (y >= 1) begin
            ctr = upper_row[x];
            r[n] = '0;
            r[n].flag = labelled(ctr);
            if (r[n].flag) begin
                interior = (x != 0) && !last_col && (y != 1)
                    && same_region(older_row[x - 1], ctr)
                    && same_region(upper_row[x + 1], ctr)
                    && same_region(older_row[x], ctr)
                    && same_region(cur, ctr);
                r[n].flag = !interior;
            end
            r[n].col = lrbd_pkg::COL_BITS'(x);
            r[n].row = lrbd_pkg::ROW_BITS'(y - 1);
            n++;
        end
        older_row[x] = upper_row[x];
        upper_row[x] = cur;
        if (last_row) begin
            r[n] = '0;
            r[n].flag = labelled(cur);
            r[n].col  = lrbd_pkg::COL_BITS'(x);
            r[n].row  = lrbd_pkg::ROW_BITS'(y);
            r[n].done = last_col;
            n++;
        end
        if (n > 0) r[n - 1].last_item = 1'b1;
        for (int k = 0; k < n; k++) flags_due = {flags_due, r[k]};
        if (last_col) begin
            col_pos = '0;
            row_pos = last_row ? '0 : lrbd_pkg::ROW_BITS'(y + 1);
        end else begin
            col_pos = lrbd_pkg::COL_BITS'(x + 1);
        end
    endtask

    always @(posedge i_clk) begin
        t_boundary_result want;
        if (!i_rst_n) begin
            width_reg  = lrbd_pkg::WIDTH_RESET;
            height_reg = lrbd_pkg::HEIGHT_RESET;
            nodata_en  = 1'b0;
            nodata_val = '0;
            col_pos    = '0;
            row_pos    = '0;
            flags_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (flags_due.size() == 0) begin
                    fail_cnt++;
                    $error("result with nothing pending: col %0d row %0d",
                           i_res.result_col, i_res.result_row);
                end else begin
                    want = flags_due.pop_front();
                    check_field("boundary_flag", want.flag, i_res.boundary_flag);
                    check_field("result_col", want.col, i_res.result_col);
                    check_field("result_row", want.row, i_res.result_row);
                    check_field("last_of_item", want.last_item, i_res.last_of_item);
                    check_field("frame_done", want.done, i_res.frame_done);
                end
            end
            if (i_pix.valid && i_pix.ready)
                predict_flags(i_pix.pixel_label, i_pix.in_mask);
            if (i_cfg_we) begin
                case (lrbd_pkg::t_cfg_index'(i_cfg_index))
                    lrbd_pkg::CFG_IMAGE_WIDTH:
                        width_reg  = i_cfg_data[lrbd_pkg::WIDTH_REG_BITS-1:0];
                    lrbd_pkg::CFG_IMAGE_HEIGHT:
                        height_reg = i_cfg_data[lrbd_pkg::HEIGHT_REG_BITS-1:0];
                    lrbd_pkg::CFG_NODATA_ENABLE:
                        nodata_en  = i_cfg_data[0];
                    lrbd_pkg::CFG_NODATA_VALUE:
                        nodata_val = i_cfg_data[lrbd_pkg::PIX_LABEL_BITS-1:0];
                    default: ;
                endcase
            end
        end
        pending_cnt <= flags_due.size();
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int ITEM_TARGET   = 1600;
    localparam int CYCLE_LIMIT   = 3_000_000;
    // margin for the last pixel request to reach the result queue
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                cfg_we;
    logic [lrbd_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [lrbd_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    int fail_count;
    int pending;
    int cycle_cnt;
    int sent = 0;

    // idling control shared by the pixel source and the result sink
    bit quiet    = 1'b0;
    bit hold_req = 1'b0;

    // label palette of the current phase
    logic [31:0] label_a, label_b, nd_label;
    bit          nd_on;

    lrbd_pixel_if  pix_if ();
    lrbd_result_if res_if ();

    label_raster_boundary_detect_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    lrbd_checker flag_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_if),
        .i_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run; the budget covers the slowest legal stall pattern many times over.
    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Result sink: random back-pressure, mostly short, now and then long.
    // A long hold requested by the stimulus is counted down here.
    initial begin : result_sink
        int hold;
        int r;
        hold = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold     = LONG_HOLD;
            end
            if (hold > 0) begin
                res_if.ready <= 1'b0;
                hold--;
            end else if (quiet) begin
                res_if.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    res_if.ready <= 1'b1;
                end else begin
                    res_if.ready <= 1'b0;
                    hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
        end
    end

    function automatic int idle_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one pixel request and hold it until accepted. Valid stays high
    // when the next request follows without a gap.
    task automatic push_pixel(input logic [31:0] label, input logic mask);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            pix_if.valid       <= 1'b0;
            pix_if.pixel_label <= $urandom();
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_label <= label;
        pix_if.in_mask     <= mask;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        sent++;
    endtask

    // Write all four registers back to back; unused upper data bits carry noise.
    task automatic set_config(input int unsigned w, input int unsigned h,
                              input bit en, input logic [31:0] nd);
        cfg_we    <= 1'b1;
        cfg_index <= lrbd_pkg::CFG_IMAGE_WIDTH;
        cfg_data  <= ($urandom() & ~32'h1FFF) | (w & 32'h1FFF);
        @(posedge i_clk);
        cfg_index <= lrbd_pkg::CFG_IMAGE_HEIGHT;
        cfg_data  <= ($urandom() & 32'hFFFF_0000) | (h & 32'hFFFF);
        @(posedge i_clk);
        cfg_index <= lrbd_pkg::CFG_NODATA_ENABLE;
        cfg_data  <= ($urandom() & ~32'h1) | en;
        @(posedge i_clk);
        cfg_index <= lrbd_pkg::CFG_NODATA_VALUE;
        cfg_data  <= nd;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Drop valid and wait until every predicted result has drained, then let
    // any row-0 request that produces nothing clear the pipeline.
    task automatic settle();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Stream pixels from the phase palette: mostly one region label so that
    // interior pixels occur, with a second label, nodata and stray labels mixed in.
    task automatic send_pixels(input int unsigned count);
        int          r;
        logic [31:0] lab;
        for (int unsigned i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 72)      lab = label_a;
            else if (r < 88) lab = label_b;
            else if (r < 94) lab = nd_label;
            else             lab = $urandom();
            push_pixel(lab, $urandom_range(0, 9) != 0);
        end
    endtask

    initial begin : stimulus
        int          phase;
        int          base;
        int          r;
        int unsigned w, h, cols, rows;
        int unsigned nframes;
        i_rst_n            <= 1'b0;
        pix_if.valid       <= 1'b0;
        pix_if.pixel_label <= '0;
        pix_if.in_mask     <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= lrbd_pkg::CFG_IMAGE_WIDTH;
        cfg_data           <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: one row of full width, nodata off. Labels at the two
        // ends of the signed range are sent.
        quiet = 1'b1;
        push_pixel(32'h7FFF_FFFF, 1'b1);
        push_pixel(32'h8000_0000, 1'b1);
        settle();
        // width above the store size clamps; the row simply goes on
        set_config(8191, 1, 1'b0, 32'h0);
        push_pixel(32'h0000_0000, 1'b1);
        push_pixel(32'hFFFF_FFFF, 1'b0);
        settle();
        // shrink the width mid-row: the next pixel closes row and frame
        set_config(2, 1, 1'b0, 32'h0);
        push_pixel(32'h1234_5678, 1'b1);
        settle();

        // zero width and height behave as one; nodata at the most negative label
        quiet = 1'b0;
        set_config(0, 0, 1'b1, 32'h8000_0000);
        push_pixel(32'h8000_0000, 1'b1);
        push_pixel(32'h0000_0005, 1'b1);
        push_pixel(32'h8000_0000, 1'b0);
        settle();

        // 3x3 of one label: only the center is interior
        set_config(3, 3, 1'b1, 32'hFFFF_FFFF);
        repeat (9) push_pixel(32'h0000_0007, 1'b1);
        settle();

        // cut the height mid-frame: row 2 becomes the last row
        set_config(2, 5, 1'b1, 32'hFFFF_FFFF);
        repeat (4) push_pixel(32'h0000_0009, 1'b1);
        settle();
        set_config(2, 1, 1'b1, 32'hFFFF_FFFF);
        push_pixel(32'h0000_0009, 1'b1);
        push_pixel(32'hFFFF_FFFF, 1'b1);
        settle();

        // Random phases: mostly whole frames, a few cut short.
        phase = 0;
        base  = sent;
        while (sent - base < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 5)       w = 0;
            else if (r < 80) w = $urandom_range(1, 8);
            else             w = $urandom_range(9, 40);
            r = $urandom_range(0, 99);
            if (r < 5)       h = 0;
            else if (r < 70) h = $urandom_range(1, 6);
            else             h = $urandom_range(7, 16);
            if (phase == 0) begin
                w = 16;
                h = 12;
            end
            r = $urandom_range(0, 9);
            if (r == 0)      label_a = 32'h8000_0000;
            else if (r == 1) label_a = 32'h7FFF_FFFF;
            else             label_a = $urandom();
            label_b  = $urandom();
            nd_label = $urandom_range(0, 1) ? label_b : $urandom();
            nd_on    = $urandom_range(0, 1);
            quiet    = (phase != 0) && ($urandom_range(0, 4) == 0);
            set_config(w, h, nd_on, nd_label);
            cols = (w < 1) ? 1 : w;
            rows = (h < 1) ? 1 : h;
            // first phase: starve the result side long enough to back up the input
            if (phase == 0) hold_req = 1'b1;
            // keep the total close to the target: trim the frame count near the end
            nframes = $urandom_range(1, 3);
            while (nframes > 1 && cols * rows * nframes > ITEM_TARGET - (sent - base))
                nframes--;
            send_pixels(cols * rows * nframes);
            if ($urandom_range(0, 9) == 0 && cols * rows > 1) begin
                // broken frame: stop part way and close it with a 1x1 setting
                send_pixels($urandom_range(1, cols * rows - 1));
                settle();
                set_config(1, 1, nd_on, nd_label);
                push_pixel($urandom(), 1'b1);
            end
            settle();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
